[rtl/cttt_pkg.sv]
// Package for the cooperative task timer table.
// Holds the request codes, result codes and the structs passed between the
// controller and the slot cells. Depends on nothing.
package cttt_pkg;

   localparam int OP_W    = 2;
   localparam int TASK_W  = 8;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 8;
   localparam int KIND_W  = 2;
   localparam int PEND_W  = 8;
   localparam int COUNT_W = 4;

   // At most this many run results come from one dispatch.
   localparam logic [COUNT_W-1:0] RESULT_LIMIT = 4'd8;

   localparam logic [PEND_W-1:0] PENDING_MAX = 8'hFF;

   // Request operations.
   localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
   localparam logic [OP_W-1:0] OP_DISPATCH = 2'd3;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOTHING = 2'd3;

   // Request fields broadcast from the controller to every cell.
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [TASK_W-1:0] task_id;
      logic [TIME_W-1:0] first_delay;
      logic [TIME_W-1:0] repeat_period;
      logic [SLOT_W-1:0] slot_index;
   } cmd_type;

   // Controls broadcast from the controller to every cell.
   typedef struct packed {
      logic step;       // the token moves one cell and its holder acts
      logic add_open;   // no free slot has been claimed yet by this add
      logic emit_ok;    // dispatch may still emit a run result
   } ctl_type;

   // Status a cell reports while it holds the token.
   typedef struct packed {
      logic              hit;   // add: slot is free; dispatch: slot is due
      logic [TASK_W-1:0] task_id;
   } stat_type;

endpackage

[rtl/cttt_cell.sv]
// One slot cell of the cooperative task timer table.
// Holds the state of one task slot and passes the scan token to its neighbor.
// Depends on cttt_pkg.
module cttt_cell #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cttt_pkg::cmd_type  cmd,
   input  cttt_pkg::ctl_type  ctl,
   input  logic               token_in,
   output logic               token_out,
   output cttt_pkg::stat_type stat
);

   logic                         token_ff, token_in_next;
   logic                         used_ff, used_in;
   logic [cttt_pkg::TASK_W-1:0]  task_ff, task_in;
   logic [cttt_pkg::TIME_W-1:0]  countdown_ff, countdown_in;
   logic [cttt_pkg::TIME_W-1:0]  period_ff, period_in;
   logic [cttt_pkg::PEND_W-1:0]  pending_ff, pending_in;
   logic                         active;
   logic                         due;

   assign active    = token_ff && ctl.step;
   assign due       = used_ff && (pending_ff != '0);
   assign token_out = token_ff;

   // The status depends on the request: free slot for add, due slot otherwise.
   assign stat.hit     = (cmd.operation == cttt_pkg::OP_ADD) ? !used_ff : due;
   assign stat.task_id = task_ff;

   // Token moves one cell per step.
   assign token_in_next = ctl.step ? token_in : token_ff;

   // Slot update while this cell holds the token.
   always_comb begin
      used_in      = used_ff;
      task_in      = task_ff;
      countdown_in = countdown_ff;
      period_in    = period_ff;
      pending_in   = pending_ff;
      if (active) begin
         case (cmd.operation)
            cttt_pkg::OP_ADD: begin
               if (!used_ff && ctl.add_open) begin
                  used_in      = 1'b1;
                  task_in      = cmd.task_id;
                  countdown_in = cmd.first_delay;
                  period_in    = cmd.repeat_period;
                  pending_in   = '0;
               end
            end
            cttt_pkg::OP_DELETE: begin
               if (cmd.slot_index == cttt_pkg::SLOT_W'(INDEX)) begin
                  used_in = 1'b0;
               end
            end
            cttt_pkg::OP_TICK: begin
               if (used_ff) begin
                  if (countdown_ff == '0) begin
                     if (pending_ff != cttt_pkg::PENDING_MAX) begin
                        pending_in = pending_ff + 1'b1;
                     end
                     if (period_ff != '0) begin
                        countdown_in = period_ff;
                     end
                  end else begin
                     countdown_in = countdown_ff - 1'b1;
                  end
               end
            end
            default: begin
               // Dispatch: take one run off a due slot; one-shot slots are freed.
               if (due && ctl.emit_ok) begin
                  pending_in = pending_ff - 1'b1;
                  if (period_ff == '0) begin
                     used_in = 1'b0;
                  end
               end
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         used_ff  <= 1'b0;
      end else begin
         token_ff <= token_in_next;
         used_ff  <= used_in;
      end
   end

   // Slot payload; only read while the slot is used.
   always_ff @(posedge clock) begin
      task_ff      <= task_in;
      countdown_ff <= countdown_in;
      period_ff    <= period_in;
      pending_ff   <= pending_in;
   end

endmodule

[rtl/cooperative_task_timer_table.sv]
// Cooperative task timer table: a chain of MAX_TASKS slot cells and a controller.
// Each request sends a token down the chain, one cell per cycle, and the cell
// holding it acts on the request. A request passes the load, scan and finish
// states, and the next is taken only once the block is idle again. The token
// pauses while a result waits at the output.
// Synchronous reset clears every slot and leaves the block idle; depends on cttt_pkg.
module cooperative_task_timer_table #(
   parameter int MAX_TASKS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cttt_pkg::OP_W-1:0]     req_operation,
   input  logic [cttt_pkg::TASK_W-1:0]   req_task_id,
   input  logic [cttt_pkg::TIME_W-1:0]   req_first_delay,
   input  logic [cttt_pkg::TIME_W-1:0]   req_repeat_period,
   input  logic [cttt_pkg::SLOT_W-1:0]   req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cttt_pkg::KIND_W-1:0]   rsp_result_kind,
   output logic [cttt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [cttt_pkg::TASK_W-1:0]   rsp_run_task_id,
   output logic                          rsp_table_full,
   output logic                          rsp_last
);

   localparam int PTR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOAD   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   typedef struct packed {
      logic [cttt_pkg::KIND_W-1:0] kind;
      logic [cttt_pkg::SLOT_W-1:0] slot;
      logic [cttt_pkg::TASK_W-1:0] task_id;
      logic                        full;
      logic                        last;
   } res_type;

   logic [1:0]                     state_ff, state_in;
   cttt_pkg::cmd_type              cmd_ff, cmd_in;
   logic [PTR_W-1:0]               ptr_ff, ptr_in;
   logic                           found_ff, found_in;
   logic [PTR_W-1:0]               found_idx_ff, found_idx_in;
   logic [cttt_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           hold_valid_ff, hold_valid_in;
   res_type                        hold_ff, hold_in;
   logic                           out_valid_ff, out_valid_in;
   res_type                        out_ff, out_in;

   cttt_pkg::ctl_type              ctl;
   cttt_pkg::stat_type             stat [MAX_TASKS];
   logic [MAX_TASKS-1:0]           tok_out;
   logic                           accept;
   logic                           scan_step;
   cttt_pkg::stat_type             cur;
   res_type                        run_res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign scan_step = (state_ff == ST_SCAN) && !out_valid_ff;

   assign ctl.step     = (state_ff == ST_LOAD) || scan_step;
   assign ctl.add_open = !found_ff;
   assign ctl.emit_ok  = (count_ff < cttt_pkg::RESULT_LIMIT);

   // Status of the cell that holds the token.
   assign cur = stat[ptr_ff];

   assign run_res.kind    = cttt_pkg::KIND_RUN;
   assign run_res.slot    = cttt_pkg::SLOT_W'(ptr_ff);
   assign run_res.task_id = cur.task_id;
   assign run_res.full    = 1'b0;
   assign run_res.last    = 1'b0;

   // Chain of slot cells; the token enters cell zero in the load cycle.
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      logic chain_in;
      if (i == 0) begin : g_head
         assign chain_in = (state_ff == ST_LOAD);
      end else begin : g_link
         assign chain_in = tok_out[i-1];
      end
      cttt_cell #(
         .INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .ctl      (ctl),
         .token_in (chain_in),
         .token_out(tok_out[i]),
         .stat     (stat[i])
      );
   end

   // Controller: sequence the scan and collect results.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      count_in      = count_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      // The output register empties when its result is taken.
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in.operation     = req_operation;
               cmd_in.task_id       = req_task_id;
               cmd_in.first_delay   = req_first_delay;
               cmd_in.repeat_period = req_repeat_period;
               cmd_in.slot_index    = req_slot_index;
               ptr_in               = '0;
               found_in             = 1'b0;
               count_in             = '0;
               hold_valid_in        = 1'b0;
               state_in             = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_step) begin
               // Note the first free slot of an add.
               if (cmd_ff.operation == cttt_pkg::OP_ADD && !found_ff && cur.hit) begin
                  found_in     = 1'b1;
                  found_idx_in = ptr_ff;
               end
               // A due slot of a dispatch: the held result moves out, this one is held.
               if (cmd_ff.operation == cttt_pkg::OP_DISPATCH && cur.hit && ctl.emit_ok) begin
                  if (hold_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = hold_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_in       = run_res;
                  count_in      = count_ff + 1'b1;
               end
               if (ptr_ff == PTR_W'(MAX_TASKS - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            // Final result of the request, marked last.
            if (!out_valid_ff) begin
               out_valid_in   = 1'b1;
               out_in.last    = 1'b1;
               out_in.task_id = '0;
               out_in.full    = 1'b0;
               case (cmd_ff.operation)
                  cttt_pkg::OP_ADD: begin
                     out_in.kind = cttt_pkg::KIND_ADD;
                     out_in.slot = found_ff ? cttt_pkg::SLOT_W'(found_idx_ff)
                                            : cttt_pkg::SLOT_W'(MAX_TASKS);
                     out_in.full = !found_ff;
                  end
                  cttt_pkg::OP_DELETE: begin
                     out_in.kind = cttt_pkg::KIND_ACK;
                     out_in.slot = cmd_ff.slot_index;
                  end
                  cttt_pkg::OP_TICK: begin
                     out_in.kind = cttt_pkg::KIND_ACK;
                     out_in.slot = '0;
                  end
                  default: begin
                     if (hold_valid_ff) begin
                        out_in      = hold_ff;
                        out_in.last = 1'b1;
                     end else begin
                        out_in.kind = cttt_pkg::KIND_NOTHING;
                        out_in.slot = '0;
                     end
                  end
               endcase
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         count_ff      <= '0;
         ptr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
         found_ff      <= found_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      found_idx_ff <= found_idx_in;
      hold_ff      <= hold_in;
      out_ff       <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_ff.kind;
   assign rsp_slot        = out_ff.slot;
   assign rsp_run_task_id = out_ff.task_id;
   assign rsp_table_full  = out_ff.full;
   assign rsp_last        = out_ff.last;

endmodule
